### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define SMK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Stalled item must stay offered and unchanged.
`define SMK_ASSERT_STALL(lbl, clk, rst, vld, rdy, data, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      ((vld) && !(rdy)) |=> ((vld) && $stable(data))) else $error(msg);

`endif

### rtl/core/smk_pkg.sv
`timescale 1ns / 1ps

package smk_pkg;

   localparam int WINDOW     = 256;
   localparam int AW         = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int S_MAX      = WINDOW * (WINDOW - 1) / 2;
   localparam int S_W        = $clog2(S_MAX + 1) + 1;
   localparam int MAG_W      = S_W - 1;
   localparam int FRAC_SHIFT = 17;
   localparam int NUM_W      = MAG_W + FRAC_SHIFT;
   localparam int DEN_W      = 2 * CNT_W;

   localparam int SAMPLE_W   = 32;
   localparam int STAT_W     = 16;
   localparam int COUNT_W    = 9;
   localparam int TREND_W    = 17;
   localparam int CFG_W      = 9;
   localparam int TREND_ONE  = 65536;
   localparam int STAT_MAX   = 2 ** (STAT_W - 1) - 1;
   localparam int STAT_MIN   = -(2 ** (STAT_W - 1));
   localparam int COUNT_MAX  = 2 ** COUNT_W - 1;

   localparam logic [CFG_W-1:0] WLEN_RESET = CFG_W'(256);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_ADD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } smk_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } smk_div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } smk_div_sts_type;

endpackage

### rtl/core/smk_req_if.sv
`timescale 1ns / 1ps

interface smk_req_if;
   import smk_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

### rtl/core/smk_rsp_if.sv
`timescale 1ns / 1ps

interface smk_rsp_if;
   import smk_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [STAT_W-1:0] s_stat;
   logic [COUNT_W-1:0]       sample_count;
   logic [TREND_W-1:0]       trend;
   logic                     window_full;

   modport source (output valid, output s_stat, output sample_count, output trend,
                   output window_full, input ready);
   modport sink   (input valid, input s_stat, input sample_count, input trend,
                   input window_full, output ready);
endinterface

### rtl/core/smk_divider.sv
`timescale 1ns / 1ps

module smk_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  smk_pkg::smk_div_req_type     div_req,
   output smk_pkg::smk_div_sts_type     div_sts,
   output logic [smk_pkg::NUM_W-1:0]    quotient
);
   import smk_pkg::*;

   localparam int IT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [IT_W-1:0]  iter_ff, iter_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         work_in = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         iter_in = IT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         work_in = {work_ff[NUM_W-2:0], fits};
         iter_in = iter_ff - 1'b1;
         if (iter_ff == IT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = work_ff;

endmodule

### rtl/core/sliding_mann_kendall_trend_unit.sv
`timescale 1ns / 1ps

// Sliding-window Mann-Kendall trend unit. Samples live in a 256-entry ring
// memory with a registered read; S is kept up to date one item at a time.
// One item is handled at a time; the next item is taken once the result has
// been handed to the output register. An add below capacity runs one add
// pass; at capacity a drop pass runs first and then the add pass, with one
// memory read per held sample in each. The divider is then started, the
// 32-step restoring divider raises its done flag and the result register is
// loaded. When fewer than two samples remain the divider is skipped. A clear
// item goes straight to the output state. A write to csr_wdata sets the
// capacity (0 or above 256 means 256) and empties the window; it must only be
// issued while the unit is idle.

module sliding_mann_kendall_trend_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [smk_pkg::CFG_W-1:0] csr_wdata,
   smk_req_if.sink                   req_ch,
   smk_rsp_if.source                 rsp_ch
);
   import smk_pkg::*;

   smk_state_type state_ff, state_in;

   logic [CFG_W-1:0]           wlen_ff, wlen_in;
   logic [AW-1:0]              oldest_ff, oldest_in;
   logic [CNT_W-1:0]           held_ff, held_in;
   logic signed [S_W-1:0]      s_ff, s_in;
   logic                       full_ff, full_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       first_ff, first_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] x0_ff, x0_in;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic [TREND_W-1:0]         trend_ff, trend_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [STAT_W-1:0]   rsp_s_ff, rsp_s_in;
   logic [COUNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic [TREND_W-1:0]         rsp_trend_ff, rsp_trend_in;
   logic                       rsp_full_ff, rsp_full_in;

   logic signed [SAMPLE_W-1:0] ring [WINDOW];

   logic [CNT_W-1:0]           cap;
   logic                       accept;
   logic                       in_pass, issue, pass_done, acc_en, wr_en;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic signed [SAMPLE_W-1:0] cmp_ref;
   logic signed [1:0]          term;
   logic [MAG_W-1:0]           mag;
   logic signed [31:0]         s_wide;
   logic [31:0]                held_wide;
   logic                       out_free;

   smk_div_req_type            div_req;
   smk_div_sts_type            div_sts;
   logic [NUM_W-1:0]           quotient;

   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (32'(sum) >= WINDOW) begin
         sum = sum - (CNT_W + 1)'(WINDOW);
      end
      return AW'(sum);
   endfunction

   smk_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_sts  (div_sts),
      .quotient (quotient)
   );

   always_comb begin
      if (wlen_ff == '0 || 32'(wlen_ff) > WINDOW) begin
         cap = CNT_W'(WINDOW);
      end else begin
         cap = CNT_W'(wlen_ff);
      end
   end

   assign accept    = req_ch.valid && req_ch.ready;
   assign in_pass   = (state_ff == ST_DROP) || (state_ff == ST_ADD);
   assign issue     = in_pass && (cnt_ff < held_ff);
   assign pass_done = in_pass && (cnt_ff == held_ff) && !rd_vld_ff;
   assign acc_en    = rd_vld_ff && !((state_ff == ST_DROP) && first_ff);
   assign rd_addr   = ring_addr(oldest_ff, cnt_ff);
   assign wr_addr   = ring_addr(oldest_ff, held_ff);
   assign cmp_ref   = (state_ff == ST_DROP) ? x0_ff : x_ff;
   assign term      = (cmp_ref > rd_data_ff) ? 2'sb01 :
                      (cmp_ref < rd_data_ff) ? 2'sb11 : 2'sb00;
   assign mag       = s_ff[S_W-1] ? MAG_W'(-s_ff) : MAG_W'(s_ff);
   assign s_wide    = 32'(s_ff);
   assign held_wide = 32'(held_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.cmd == CMD_CLEAR) begin
                  state_in = ST_OUT;
               end else if (held_ff >= cap) begin
                  state_in = ST_DROP;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_DROP: begin
            if (pass_done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (pass_done) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            state_in = (held_ff > CNT_W'(1)) ? ST_DIV_WAIT : ST_OUT;
         end
         ST_DIV_WAIT: begin
            if (div_sts.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wlen_in      = wlen_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      s_in         = s_ff;
      full_in      = full_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      first_in     = first_ff;
      x_in         = x_ff;
      x0_in        = x0_ff;
      trend_in     = trend_ff;
      wr_en        = 1'b0;
      div_req      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_s_in     = rsp_s_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_trend_in = rsp_trend_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_ch.sample;
               cnt_in   = '0;
               first_in = 1'b1;
               if (req_ch.cmd == CMD_CLEAR) begin
                  oldest_in = '0;
                  held_in   = '0;
                  s_in      = '0;
                  full_in   = 1'b0;
                  trend_in  = '0;
               end
            end
         end
         ST_DROP, ST_ADD: begin
            rd_vld_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (acc_en) begin
               s_in = s_ff + S_W'(term);
            end
            if ((state_ff == ST_DROP) && rd_vld_ff && first_ff) begin
               x0_in    = rd_data_ff;
               first_in = 1'b0;
            end
            if (pass_done) begin
               cnt_in = '0;
               if (state_ff == ST_DROP) begin
                  oldest_in = ring_addr(oldest_ff, CNT_W'(1));
                  held_in   = held_ff - 1'b1;
                  full_in   = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  held_in = held_ff + 1'b1;
               end
            end
         end
         ST_DIV_START: begin
            if (held_ff > CNT_W'(1)) begin
               div_req.start = 1'b1;
               div_req.num   = {mag, {FRAC_SHIFT{1'b0}}};
               div_req.den   = DEN_W'(DEN_W'(held_ff) * DEN_W'(held_ff - 1'b1));
            end else begin
               trend_in = '0;
            end
         end
         ST_DIV_WAIT: begin
            if (div_sts.done) begin
               trend_in = (quotient > NUM_W'(TREND_ONE)) ? TREND_W'(TREND_ONE)
                                                         : TREND_W'(quotient);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_trend_in = trend_ff;
               rsp_full_in  = full_ff;
               if (s_wide > STAT_MAX) begin
                  rsp_s_in = STAT_W'(STAT_MAX);
               end else if (s_wide < STAT_MIN) begin
                  rsp_s_in = STAT_W'(STAT_MIN);
               end else begin
                  rsp_s_in = STAT_W'(s_wide);
               end
               rsp_cnt_in = (held_wide > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                    : COUNT_W'(held_ff);
            end
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         wlen_in   = csr_wdata;
         oldest_in = '0;
         held_in   = '0;
         s_in      = '0;
         full_in   = 1'b0;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.s_stat       = rsp_s_ff;
   assign rsp_ch.sample_count = rsp_cnt_ff;
   assign rsp_ch.trend        = rsp_trend_ff;
   assign rsp_ch.window_full  = rsp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WLEN_RESET;
         oldest_ff    <= '0;
         held_ff      <= '0;
         s_ff         <= '0;
         full_ff      <= 1'b0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         s_ff         <= s_in;
         full_ff      <= full_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      x0_ff        <= x0_in;
      trend_ff     <= trend_in;
      rsp_s_ff     <= rsp_s_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_trend_ff <= rsp_trend_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= ring[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wr_addr] <= x_ff;
      end
   end

endmodule

### rtl/core/smk_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smk_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [smk_pkg::STAT_W-1:0]  s_stat,
   input logic [smk_pkg::COUNT_W-1:0]        sample_count,
   input logic [smk_pkg::TREND_W-1:0]        trend,
   input logic                               window_full
);
   import smk_pkg::*;

   `SMK_ASSERT_STALL(a_rsp_hold, clock, reset, rsp_valid, rsp_ready, {s_stat, sample_count, trend, window_full}, "result item changed while stalled")
   `SMK_ASSERT(a_trend_small_n, clock, reset, (rsp_valid && sample_count < COUNT_W'(2)) |-> (trend == '0), "trend not zero below two samples")
   `SMK_ASSERT(a_empty_window, clock, reset, (rsp_valid && sample_count == '0) |-> (s_stat == '0 && !window_full), "empty window with stale statistic")
   `SMK_ASSERT(a_bounds, clock, reset, rsp_valid |-> (32'(trend) <= TREND_ONE && 32'(sample_count) <= WINDOW), "trend or count out of range")

endmodule

bind sliding_mann_kendall_trend_unit smk_checker u_smk_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .s_stat       (rsp_ch.s_stat),
   .sample_count (rsp_ch.sample_count),
   .trend        (rsp_ch.trend),
   .window_full  (rsp_ch.window_full)
);
